### hw/rtl/two_track_resampling_mixer_core_macros.svh
// Assertion macros for the two-track resampling mixer.
`ifndef TWO_TRACK_RESAMPLING_MIXER_CORE_MACROS_SVH
`define TWO_TRACK_RESAMPLING_MIXER_CORE_MACROS_SVH

// same-cycle implication
`define TTRM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TTRM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/ttrm_pkg.sv
// Package: word types, codes and constants of the two-track resampling mixer.
package ttrm_pkg;

    localparam int unsigned DEF_TRACK_FRAMES = 262144;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 20;
    localparam int unsigned LEN_REG_W  = 19;
    localparam int unsigned STEP_W     = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_A    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_B    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_A      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_B      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOADED_A    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LOADED_B    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MASTER_GAIN = 3'd6;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_SET  = 2'd1;
    localparam logic [1:0] OP_MIX  = 2'd2;

    localparam logic [LEN_REG_W-1:0] LENGTH_RESET = 19'd262144;
    localparam logic [STEP_W-1:0]    STEP_RESET   = 20'd65536;
    localparam logic [15:0]          GAIN_RESET   = 16'd24576;
    localparam logic [15:0]          UNITY_Q15    = 16'd32768;

    typedef struct packed {
        logic [1:0]         operation;
        logic               track_select;
        logic [17:0]        frame_index;
        logic signed [15:0] left_value;
        logic signed [15:0] right_value;
        logic               track_active;
        logic [15:0]        track_volume;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] mix_left;
        logic signed [15:0] mix_right;
    } t_out_word;

endpackage

### hw/rtl/two_track_resampling_mixer_core.sv
// Two-track resampling mixer: channels, config, sequencer and shared mul/mod units.
//
// Input channel (i_in_valid / o_in_stall) takes one word: a sample frame load,
// a track state set, or a game frame to mix. Output channel (o_out_valid /
// i_out_stall) gives one mixed stereo word for each mix word, none otherwise.
// Config is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data).
// Load and set words finish in the cycle they are taken. A mix word runs a
// sequencer over one shared 34x18 multiplier and one bit-serial restoring
// modulo unit: per playing track a modulo pass for the read position, the
// sample reads, interpolation, volume and a second modulo pass to advance the
// position, then gain and saturation. The block takes no new word while a mix
// runs. The result sits in an output register; a stalled receiver holds it,
// and the next word is taken meanwhile, a new mix waiting at its last step
// until the register frees. Synchronous reset clears track state and the
// output valid and sets the config registers to their defaults; the sample
// memory needs no clearing pass, so the block is ready straight out of reset.
module two_track_resampling_mixer_core #(
    parameter int unsigned TRACK_FRAMES = ttrm_pkg::DEF_TRACK_FRAMES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  ttrm_pkg::t_in_word               i_in_word,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output ttrm_pkg::t_out_word              o_out_word,
    input  logic                             i_cfg_we,
    input  logic [ttrm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ttrm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import ttrm_pkg::*;

    localparam int unsigned LEN_W = $clog2(TRACK_FRAMES + 1);
    localparam int unsigned AW    = $clog2(2 * TRACK_FRAMES);
    localparam int unsigned POS_W = LEN_W + 16;
    localparam int unsigned DIV_W = POS_W + 1;
    localparam int unsigned CNT_W = $clog2(DIV_W);
    localparam int unsigned CW    = (LEN_W > LEN_REG_W) ? LEN_W : LEN_REG_W;
    localparam int unsigned IW    = (LEN_W > 18) ? LEN_W : 18;

    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_CHK  = 14'b00000000000010,
        S_MOD  = 14'b00000000000100,
        S_RD0  = 14'b00000000001000,
        S_RD1  = 14'b00000000010000,
        S_IL   = 14'b00000000100000,
        S_IR   = 14'b00000001000000,
        S_WL   = 14'b00000010000000,
        S_WR   = 14'b00000100000000,
        S_ADV  = 14'b00001000000000,
        S_GL   = 14'b00010000000000,
        S_GR   = 14'b00100000000000,
        S_FIN  = 14'b01000000000000,
        S_PUT  = 14'b10000000000000
    } t_state;

    function automatic logic signed [15:0] f_interp(input logic signed [15:0] s0,
                                                    input logic signed [51:0] prod);
        logic signed [33:0] num;
        num = {{2{s0[15]}}, s0, 16'd0} + prod[33:0];
        if (num < 0) begin
            num = num + 34'sd65535;
        end
        return num[31:16];
    endfunction

    function automatic logic signed [15:0] f_finish(input logic signed [15:0] game,
                                                    input logic signed [51:0] prod);
        logic signed [66:0] ext;
        logic signed [66:0] q;
        logic signed [21:0] e;
        logic signed [22:0] sum;
        ext = {{15{prod[51]}}, prod};
        q   = (ext <<< 15) - ext;
        if (q < 0) begin
            q = q + 67'sh1FFFFFFFFFFF;
        end
        e   = q[66:45];
        sum = {{7{game[15]}}, game} + {e[21], e};
        if (sum > 23'sd32767) begin
            return 16'sh7FFF;
        end else if (sum < -23'sd32768) begin
            return 16'sh8000;
        end
        return sum[15:0];
    endfunction

    t_state r_state, n_state;
    t_in_word r_in;
    logic [LEN_REG_W-1:0] r_len [2];
    logic [STEP_W-1:0] r_step [2];
    logic r_loaded [2];
    logic [15:0] r_gain;
    logic [POS_W-1:0] r_pos [2];
    logic r_playing [2];
    logic [15:0] r_level [2];
    logic r_t;
    logic r_sel;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_dvd;
    logic [POS_W-1:0] r_rem, n_rem;
    logic [POS_W-1:0] r_p;
    logic [31:0] r_mem_q, r_w0;
    logic signed [51:0] r_prod;
    logic signed [15:0] r_il, r_ir, r_out_l, r_out_r;
    logic signed [33:0] r_acc_l, r_acc_r;
    logic r_out_valid;
    t_out_word r_out;
    logic [31:0] mem [2*TRACK_FRAMES];

    logic in_acc;
    logic [LEN_W-1:0] eff_len, cur, nxt, cur_inc;
    logic [POS_W-1:0] span;
    logic active;
    logic [DIV_W-1:0] rem2;
    logic [AW-1:0] base, rd_addr, wr_addr;
    logic rd_en, wr_en, mul_en;
    logic signed [33:0] m_a;
    logic signed [17:0] m_b;
    logic [15:0] gain_c, vol_c;
    logic set_now;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    assign eff_len = (CW'(r_len[r_t]) > CW'(TRACK_FRAMES)) ? LEN_W'(TRACK_FRAMES)
                                                          : LEN_W'(r_len[r_t]);
    assign span    = {eff_len, 16'd0};
    assign active  = r_playing[r_t] && r_loaded[r_t] && (eff_len != '0);
    assign cur     = r_p[POS_W-1:16];
    assign cur_inc = cur + LEN_W'(1);
    assign nxt     = (cur_inc == eff_len) ? '0 : cur_inc;
    assign base    = r_t ? AW'(TRACK_FRAMES) : '0;
    assign rd_addr = base + ((r_state == S_RD0) ? AW'(cur) : AW'(nxt));
    assign rd_en   = (r_state == S_RD0) || (r_state == S_RD1);
    assign wr_en   = in_acc && (i_in_word.operation == OP_LOAD)
                     && (IW'(i_in_word.frame_index) < IW'(TRACK_FRAMES));
    assign wr_addr = (i_in_word.track_select ? AW'(TRACK_FRAMES) : '0)
                     + AW'(i_in_word.frame_index);

    assign rem2  = {r_rem, r_dvd[DIV_W-1]};
    assign n_rem = (rem2 >= {1'b0, span}) ? POS_W'(rem2 - {1'b0, span}) : rem2[POS_W-1:0];

    assign gain_c  = (r_gain > UNITY_Q15) ? UNITY_Q15 : r_gain;
    assign vol_c   = (i_in_word.track_volume > UNITY_Q15) ? UNITY_Q15
                                                         : i_in_word.track_volume;
    assign set_now = i_in_word.track_active && r_loaded[i_in_word.track_select];

    always_comb begin
        m_a    = '0;
        m_b    = '0;
        mul_en = 1'b1;
        case (r_state)
            S_IL: begin
                m_a = 34'(signed'({r_mem_q[15], r_mem_q[15:0]})
                          - signed'({r_w0[15], r_w0[15:0]}));
                m_b = signed'({2'b00, r_p[15:0]});
            end
            S_IR: begin
                m_a = 34'(signed'({r_mem_q[31], r_mem_q[31:16]})
                          - signed'({r_w0[31], r_w0[31:16]}));
                m_b = signed'({2'b00, r_p[15:0]});
            end
            S_WL: begin
                m_a = 34'(r_il);
                m_b = signed'({2'b00, r_level[r_t]});
            end
            S_WR: begin
                m_a = 34'(r_ir);
                m_b = signed'({2'b00, r_level[r_t]});
            end
            S_GL: begin
                m_a = r_acc_l;
                m_b = signed'({2'b00, gain_c});
            end
            S_GR: begin
                m_a = r_acc_r;
                m_b = signed'({2'b00, gain_c});
            end
            default: mul_en = 1'b0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (in_acc && i_in_word.operation == OP_MIX) n_state = S_CHK;
            S_CHK: begin
                if (active) begin
                    n_state = S_MOD;
                end else if (r_t) begin
                    n_state = S_GL;
                end
            end
            S_MOD: begin
                if (r_cnt == '0) begin
                    if (!r_sel) begin
                        n_state = S_RD0;
                    end else if (r_t) begin
                        n_state = S_GL;
                    end else begin
                        n_state = S_CHK;
                    end
                end
            end
            S_RD0: n_state = S_RD1;
            S_RD1: n_state = S_IL;
            S_IL:  n_state = S_IR;
            S_IR:  n_state = S_WL;
            S_WL:  n_state = S_WR;
            S_WR:  n_state = S_ADV;
            S_ADV: n_state = S_MOD;
            S_GL:  n_state = S_GR;
            S_GR:  n_state = S_FIN;
            S_FIN: n_state = S_PUT;
            S_PUT: if (!r_out_valid || !i_out_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= {i_in_word.right_value, i_in_word.left_value};
        end
        if (rd_en) begin
            r_mem_q <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= m_a * m_b;
        end
        if (in_acc) begin
            r_in <= i_in_word;
        end
        case (r_state)
            S_IDLE: begin
                r_acc_l <= '0;
                r_acc_r <= '0;
            end
            S_CHK: begin
                r_dvd <= DIV_W'(r_pos[r_t]);
                r_rem <= '0;
                r_cnt <= CNT_W'(DIV_W - 1);
                r_sel <= 1'b0;
            end
            S_MOD: begin
                r_dvd <= r_dvd << 1;
                r_rem <= n_rem;
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0 && !r_sel) begin
                    r_p <= n_rem;
                end
            end
            S_RD1: r_w0 <= r_mem_q;
            S_IR:  r_il <= f_interp(r_w0[15:0], r_prod);
            S_WL:  r_ir <= f_interp(r_w0[31:16], r_prod);
            S_WR:  r_acc_l <= r_acc_l + r_prod[33:0];
            S_ADV: begin
                r_acc_r <= r_acc_r + r_prod[33:0];
                r_dvd   <= DIV_W'(r_p) + DIV_W'(r_step[r_t]);
                r_rem   <= '0;
                r_cnt   <= CNT_W'(DIV_W - 1);
                r_sel   <= 1'b1;
            end
            S_GR:  r_out_l <= f_finish(r_in.left_value, r_prod);
            S_FIN: r_out_r <= f_finish(r_in.right_value, r_prod);
            S_PUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    r_out.mix_left  <= r_out_l;
                    r_out.mix_right <= r_out_r;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_t         <= 1'b0;
            r_out_valid <= 1'b0;
            r_len[0]    <= LENGTH_RESET;
            r_len[1]    <= LENGTH_RESET;
            r_step[0]   <= STEP_RESET;
            r_step[1]   <= STEP_RESET;
            r_loaded[0] <= 1'b0;
            r_loaded[1] <= 1'b0;
            r_gain      <= GAIN_RESET;
            r_pos[0]    <= '0;
            r_pos[1]    <= '0;
            r_playing[0] <= 1'b0;
            r_playing[1] <= 1'b0;
            r_level[0]  <= '0;
            r_level[1]  <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LENGTH_A:    r_len[0]    <= i_cfg_data[LEN_REG_W-1:0];
                    CFG_LENGTH_B:    r_len[1]    <= i_cfg_data[LEN_REG_W-1:0];
                    CFG_STEP_A:      r_step[0]   <= i_cfg_data;
                    CFG_STEP_B:      r_step[1]   <= i_cfg_data;
                    CFG_LOADED_A:    r_loaded[0] <= i_cfg_data[0];
                    CFG_LOADED_B:    r_loaded[1] <= i_cfg_data[0];
                    CFG_MASTER_GAIN: r_gain      <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (in_acc && i_in_word.operation == OP_SET) begin
                r_playing[i_in_word.track_select] <= set_now;
                r_level[i_in_word.track_select]   <= vol_c;
                if (set_now && !r_playing[i_in_word.track_select]) begin
                    r_pos[i_in_word.track_select] <= '0;
                end
            end
            if (r_state == S_IDLE) begin
                r_t <= 1'b0;
            end else if (r_state == S_CHK && !active) begin
                r_t <= 1'b1;
            end else if (r_state == S_MOD && r_cnt == '0 && r_sel) begin
                r_pos[r_t] <= n_rem;
                r_t        <= 1'b1;
            end
            if (r_state == S_PUT && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `include "two_track_resampling_mixer_core_macros.svh"

    `TTRM_ASSERT_NEXT(a_mod_runs, r_state == S_MOD && r_cnt != '0, r_state == S_MOD, "modulo cut short")
    `TTRM_ASSERT_NOW(a_rem_bound, r_state == S_MOD, r_rem < span, "remainder not below span")
    `TTRM_ASSERT_NOW(a_pos_bound, r_state == S_RD0, r_p < span, "read position out of span")
    `TTRM_ASSERT_NEXT(a_put_hold, r_state == S_PUT && r_out_valid && i_out_stall, r_state == S_PUT, "result dropped")

endmodule
